/* src/spq_pkg.sv */
// Shared constants and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage
`default_nettype wire

/* src/spq_ctrl.sv */
// Controller: sequences accept, execute and result hand-off for one beat at a time.
`default_nettype none
module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_RESP;
                out_valid_next = 1'b1;
            end
            ST_RESP:
            begin
                if (!out_stall)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_valid && (state_reg == ST_IDLE);
    assign cmd.exec  = (state_reg == ST_EXEC);

endmodule
`default_nettype wire

/* src/spq_dp.sv */
// Datapath: sorted register array with per-entry compare, shift logic and result registers.
`default_nettype none
module spq_dp
    import spq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire logic [1:0]         mode,
    input  wire logic signed [31:0] value,
    output logic signed [31:0]      popped_value,
    output logic                    found,
    output logic [1:0]              status,
    output logic [4:0]              count,
    output logic                    is_empty
);

    logic [1:0]         mode_reg;
    logic signed [31:0] value_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic signed [31:0] entry_reg  [DEPTH];
    logic signed [31:0] entry_next [DEPTH];
    logic [DEPTH-1:0]   keep;
    logic [DEPTH-1:0]   hit;
    logic               full;
    logic               empty;
    logic               wr_insert;
    logic               wr_remove;

    logic signed [31:0] popped_reg;
    logic signed [31:0] popped_next;
    logic               found_reg;
    logic [1:0]         status_reg;
    status_t            status_next;
    logic [4:0]         count_reg;
    logic               is_empty_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);

    // Each stored entry compares against the operand at its own slot.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < cnt_reg) && (entry_reg[i] > value_reg);
            hit[i]  = (CNT_W'(i) < cnt_reg) && (entry_reg[i] == value_reg);
        end
    end

    always_comb
    begin
        wr_insert   = 1'b0;
        wr_remove   = 1'b0;
        cnt_next    = cnt_reg;
        popped_next = '0;
        status_next = STAT_OK;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_insert = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    wr_remove   = 1'b1;
                    popped_next = entry_reg[0];
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Insert: hold entries above the operand, drop the operand into the gap,
    // advance the rest one slot. Remove: advance every entry toward the head.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (wr_insert && !keep[i])
            begin
                if (i == 0)
                begin
                    entry_next[i] = value_reg;
                end
                else if (keep[i-1])
                begin
                    entry_next[i] = value_reg;
                end
                else
                begin
                    entry_next[i] = entry_reg[i-1];
                end
            end
            else if (wr_remove && (i < DEPTH - 1))
            begin
                entry_next[i] = entry_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
            popped_reg   <= popped_next;
            found_reg    <= (mode_reg == MODE_LOOKUP) && (|hit);
            status_reg   <= status_next;
            count_reg    <= 5'(cnt_next);
            is_empty_reg <= (cnt_next == '0);
        end
    end

    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign count        = count_reg;
    assign is_empty     = is_empty_reg;

endmodule
`default_nettype wire

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: controller plus datapath.
//
// Holds up to DEPTH signed 32-bit values in descending order.
// Input channel (in_valid / in_stall): one beat carries mode and value.
//   Insert places value ahead of every stored value less than or equal to it.
//   Remove pops the head (largest). Lookup tests membership. Mode 3 is a no-op.
// Output channel (out_valid / out_stall): one result beat per input beat with
//   popped_value, found, status, count and is_empty after the operation.
//   An insert into a full queue or a remove from an empty one leaves the
//   queue unchanged and reports the matching status code.
// Timing: an accepted beat is executed in the next cycle, and its result is
//   presented in the cycle after that. One beat is in flight at a time: the
//   next beat is accepted only once the result has been taken, following the
//   accept / execute / present sequence of the controller.
// While a result waits under out_stall, the result registers hold and
//   in_stall stays high; the queue contents are not touched.
// Reset (rst_n low, asynchronous) empties the queue and clears out_valid;
//   storage is not cleared, since slots past the count never affect a result.
`default_nettype none
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      popped_value,
    output logic                    found,
    output logic [1:0]              status,
    output logic [4:0]              count,
    output logic                    is_empty
);

    dp_cmd_t cmd;

    // Sequencing: accept a beat, execute it, hold the result until taken.
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Storage, per-slot compare and shift, and the result registers.
    spq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .value        (value),
        .popped_value (popped_value),
        .found        (found),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty)
    );

endmodule
`default_nettype wire
